// ===== rtl/s2dma_pkg.sv =====
// Shared types and constants of the strided 2-D DMA engine.
// Used by s2dma_exec, s2dma_outq and strided_2d_dma_engine; depends on nothing.
`default_nettype none

package s2dma_pkg;

  localparam int REG_WORDS_DEF = 6;
  localparam int OUTQ_DEPTH    = 4;

  localparam int WORD_CTRL   = 0;
  localparam int WORD_SRC    = 1;
  localparam int WORD_DST    = 2;
  localparam int WORD_GEOM   = 3;
  localparam int WORD_STATUS = 5;

  localparam logic CFG_REGION_BASE  = 1'b0;
  localparam logic CFG_REGION_BYTES = 1'b1;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_RETURN = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } size_t_e_t;

  typedef enum logic [1:0] {
    KIND_RDATA = 2'd0,
    KIND_WDONE = 2'd1,
    KIND_MRD   = 2'd2,
    KIND_MWR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_RANGE  = 2'd1,
    ERR_CONFIG = 2'd2
  } err_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [31:0] bus_addr;
    logic [1:0]  access_size;
    logic        sign_extend;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    kind_t       out_kind;
    logic [31:0] out_addr;
    logic [31:0] out_data;
    logic [2:0]  valid_bytes;
    err_t        error_code;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/strided_2d_dma_engine.sv =====
// Top level of the strided 2-D DMA engine: request register, datapath, result queue.
// Depends on s2dma_pkg, s2dma_exec and s2dma_outq.
//
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      request: tuser kind, tdata fields
//  m_*      out  tvalid/tready      result: tuser kind, tdata fields, tlast
//  cfg_*    in   cfg_we             region_base (0), region_bytes (1)
//
// One request per cycle when the result queue has room: it waits in the request register, and its
// results are written to the result queue as it leaves that register.
// A request is held while the queue has fewer than two free entries.
// Results leave one per cycle while m_tready is high, so the output side limits the
// rate of requests that cause two results.
// Synchronous reset clears all control state and the register file; the region resets to base 0, 24 bytes.
`default_nettype none

module strided_2d_dma_engine #(
  parameter int REG_WORDS = s2dma_pkg::REG_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // bus_addr[31:0], access_size[33:32], sign_extend[34], payload[66:35], zero pad
  input  wire logic [71:0] s_tdata,
  // req_type[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // out_addr[31:0], out_data[63:32], valid_bytes[66:64], error_code[68:67], zero pad
  output logic [71:0]      m_tdata,
  // out_kind[1:0]
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  logic            req_valid;
  s2dma_pkg::req_t req;
  logic            fire;
  logic            room2;
  logic [1:0]      nres;
  logic [1:0]      npush;
  s2dma_pkg::res_t res0;
  s2dma_pkg::res_t res1;
  s2dma_pkg::res_t dout;

  assign fire     = req_valid && room2;
  assign s_tready = !req_valid || fire;
  assign npush    = fire ? nres : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.req_type    <= s2dma_pkg::req_type_t'(s_tuser);
      req.bus_addr    <= s_tdata[31:0];
      req.access_size <= s_tdata[33:32];
      req.sign_extend <= s_tdata[34];
      req.payload     <= s_tdata[66:35];
    end
  end

  s2dma_exec #(
    .REG_WORDS (REG_WORDS)
  ) u_exec (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .fire      (fire),
    .res0      (res0),
    .res1      (res1),
    .nres      (nres)
  );

  s2dma_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .npush  (npush),
    .din0   (res0),
    .din1   (res1),
    .room2  (room2),
    .dvalid (m_tvalid),
    .dready (m_tready),
    .dout   (dout)
  );

  assign m_tdata = {3'b000, dout.error_code, dout.valid_bytes, dout.out_data, dout.out_addr};
  assign m_tuser = dout.out_kind;
  assign m_tlast = dout.last;

endmodule

`default_nettype wire

// ===== rtl/s2dma_exec.sv =====
// Register file, transfer state and the single-pass request datapath.
// Produces up to two results per request; depends on s2dma_pkg.
`default_nettype none

module s2dma_exec #(
  parameter int REG_WORDS = s2dma_pkg::REG_WORDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_idx,
  input  wire logic [31:0]       cfg_wdata,
  input  wire s2dma_pkg::req_t   req,
  input  wire logic              fire,
  output s2dma_pkg::res_t        res0,
  output s2dma_pkg::res_t        res1,
  output logic [1:0]             nres
);

  localparam int RF_BYTES = REG_WORDS * 4;
  localparam int SB       = (RF_BYTES < 32) ? RF_BYTES : 32;
  localparam int LW       = $clog2(RF_BYTES + 1);

  logic [31:0]     region_base;
  logic [4:0]      region_bytes;
  logic [8*SB-1:0] regs;
  logic [8*SB-1:0] regs_next;
  logic            busy;
  logic            busy_next;
  logic [7:0]      row_index;
  logic [7:0]      row_index_next;
  logic [8:0]      row_offset;
  logic [8:0]      row_offset_next;
  logic [31:0]     src_base;
  logic [31:0]     src_base_next;
  logic [31:0]     dst_base;
  logic [31:0]     dst_base_next;
  logic [31:0]     pend_dest;
  logic [31:0]     pend_dest_next;
  logic [2:0]      pend_cnt;
  logic [2:0]      pend_cnt_next;
  logic [7:0]      lat_hm1;
  logic [7:0]      lat_hm1_next;
  logic [8:0]      lat_width;
  logic [8:0]      lat_width_next;
  logic [7:0]      lat_ss;
  logic [7:0]      lat_ss_next;
  logic [7:0]      lat_ds;
  logic [7:0]      lat_ds_next;

  logic [2:0]      nbytes;
  logic [LW-1:0]   limit;
  logic [31:0]     off;
  logic            inrange;
  logic [8*SB-1:0] rd_vec;
  logic [31:0]     rd_word;
  logic [31:0]     rdata;
  logic [8*SB-1:0] regs_wr;
  logic [4:0]      rel;
  logic [31:0]     w3;
  logic [8:0]      geo_w;
  logic            bad_cfg;
  logic [8:0]      off_sum;
  logic            row_end;
  logic [8:0]      n_off;
  logic [31:0]     n_src;
  logic [31:0]     n_dst;
  logic [8:0]      left;
  logic [2:0]      n_cnt;

  always_comb begin
    unique case (req.access_size)
      s2dma_pkg::SIZE_BYTE: nbytes = 3'd1;
      s2dma_pkg::SIZE_HALF: nbytes = 3'd2;
      default:              nbytes = 3'd4;
    endcase
  end

  assign limit   = (LW'(region_bytes) < LW'(RF_BYTES)) ? LW'(region_bytes) : LW'(RF_BYTES);
  assign off     = req.bus_addr - region_base;
  assign inrange = (33'(off) + 33'(nbytes)) <= 33'(limit);
  assign rd_vec  = regs >> {off[4:0], 3'b000};
  assign rd_word = rd_vec[31:0];

  always_comb begin
    unique case (nbytes)
      3'd1:    rdata = {{24{req.sign_extend & rd_word[7]}}, rd_word[7:0]};
      3'd2:    rdata = {{16{req.sign_extend & rd_word[15]}}, rd_word[15:0]};
      default: rdata = rd_word;
    endcase
  end

  always_comb begin
    regs_wr = regs;
    rel     = 5'd0;
    for (int j = 0; j < SB; j++) begin
      rel = 5'(j) - off[4:0];
      if (rel < 5'(nbytes)) begin
        regs_wr[8*j +: 8] = req.payload[8*rel[1:0] +: 8];
      end
    end
  end

  assign w3      = regs_wr[32*s2dma_pkg::WORD_GEOM +: 32];
  assign geo_w   = 9'(w3[15:8]) + 9'd1;
  assign bad_cfg = (w3[7:0] != 8'd0) &&
                   ((9'(w3[31:24]) < geo_w) || (9'(w3[23:16]) < geo_w));

  assign off_sum = row_offset + 9'(pend_cnt);
  assign row_end = off_sum >= lat_width;
  assign n_off   = row_end ? 9'd0 : off_sum;
  assign n_src   = row_end ? src_base + 32'(lat_ss) : src_base;
  assign n_dst   = row_end ? dst_base + 32'(lat_ds) : dst_base;
  assign left    = lat_width - n_off;
  assign n_cnt   = (left >= 9'd4) ? 3'd4 : left[2:0];

  always_comb begin
    res0            = '0;
    res1            = '0;
    nres            = 2'd0;
    regs_next       = regs;
    busy_next       = busy;
    row_index_next  = row_index;
    row_offset_next = row_offset;
    src_base_next   = src_base;
    dst_base_next   = dst_base;
    pend_dest_next  = pend_dest;
    pend_cnt_next   = pend_cnt;
    lat_hm1_next    = lat_hm1;
    lat_width_next  = lat_width;
    lat_ss_next     = lat_ss;
    lat_ds_next     = lat_ds;
    res0.last       = 1'b1;
    unique case (req.req_type)
      s2dma_pkg::REQ_READ: begin
        nres          = 2'd1;
        res0.out_kind = s2dma_pkg::KIND_RDATA;
        if (inrange) begin
          res0.out_data = rdata;
        end else begin
          res0.error_code = s2dma_pkg::ERR_RANGE;
        end
      end
      s2dma_pkg::REQ_WRITE: begin
        nres          = 2'd1;
        res0.out_kind = s2dma_pkg::KIND_WDONE;
        if (!inrange) begin
          res0.error_code = s2dma_pkg::ERR_RANGE;
        end else begin
          regs_next = regs_wr;
          if (!busy && regs_wr[0]) begin
            if (bad_cfg) begin
              res0.error_code = s2dma_pkg::ERR_CONFIG;
            end else begin
              nres             = 2'd2;
              res0.last        = 1'b0;
              busy_next        = 1'b1;
              row_index_next   = 8'd0;
              row_offset_next  = 9'd0;
              lat_hm1_next     = w3[7:0];
              lat_width_next   = geo_w;
              lat_ds_next      = w3[23:16];
              lat_ss_next      = w3[31:24];
              src_base_next    = regs_wr[32*s2dma_pkg::WORD_SRC +: 32];
              dst_base_next    = regs_wr[32*s2dma_pkg::WORD_DST +: 32];
              pend_dest_next   = regs_wr[32*s2dma_pkg::WORD_DST +: 32];
              pend_cnt_next    = (geo_w >= 9'd4) ? 3'd4 : geo_w[2:0];
              res1.out_kind    = s2dma_pkg::KIND_MRD;
              res1.out_addr    = regs_wr[32*s2dma_pkg::WORD_SRC +: 32];
              res1.valid_bytes = 3'd4;
              res1.last        = 1'b1;
            end
          end
        end
      end
      s2dma_pkg::REQ_RETURN: begin
        if (busy) begin
          res0.out_kind    = s2dma_pkg::KIND_MWR;
          res0.out_addr    = pend_dest;
          res0.out_data    = req.payload;
          res0.valid_bytes = pend_cnt;
          row_offset_next  = n_off;
          if (row_end && (row_index >= lat_hm1)) begin
            nres      = 2'd1;
            busy_next = 1'b0;
            regs_next[0] = 1'b0;
            regs_next[32*s2dma_pkg::WORD_STATUS] = 1'b1;
          end else begin
            nres             = 2'd2;
            res0.last        = 1'b0;
            if (row_end) begin
              row_index_next = row_index + 8'd1;
            end
            src_base_next    = n_src;
            dst_base_next    = n_dst;
            pend_dest_next   = n_dst + 32'(n_off);
            pend_cnt_next    = n_cnt;
            res1.out_kind    = s2dma_pkg::KIND_MRD;
            res1.out_addr    = n_src + 32'(n_off);
            res1.valid_bytes = 3'd4;
            res1.last        = 1'b1;
          end
        end
      end
      default: begin
        nres = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base  <= '0;
      region_bytes <= 5'd24;
      regs         <= '0;
      busy         <= 1'b0;
      row_index    <= '0;
      row_offset   <= '0;
      src_base     <= '0;
      dst_base     <= '0;
      pend_dest    <= '0;
      pend_cnt     <= '0;
      lat_hm1      <= '0;
      lat_width    <= '0;
      lat_ss       <= '0;
      lat_ds       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          s2dma_pkg::CFG_REGION_BASE:  region_base  <= cfg_wdata;
          s2dma_pkg::CFG_REGION_BYTES: region_bytes <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (fire) begin
        regs       <= regs_next;
        busy       <= busy_next;
        row_index  <= row_index_next;
        row_offset <= row_offset_next;
        src_base   <= src_base_next;
        dst_base   <= dst_base_next;
        pend_dest  <= pend_dest_next;
        pend_cnt   <= pend_cnt_next;
        lat_hm1    <= lat_hm1_next;
        lat_width  <= lat_width_next;
        lat_ss     <= lat_ss_next;
        lat_ds     <= lat_ds_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/s2dma_outq.sv =====
// Result queue: takes zero, one or two results per cycle, delivers one while dready is high.
// Depends on s2dma_pkg.
`default_nettype none

module s2dma_outq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [1:0]      npush,
  input  wire s2dma_pkg::res_t din0,
  input  wire s2dma_pkg::res_t din1,
  output logic                 room2,
  output logic                 dvalid,
  input  wire logic            dready,
  output s2dma_pkg::res_t      dout
);

  localparam int PW = $clog2(s2dma_pkg::OUTQ_DEPTH);
  localparam int CW = $clog2(s2dma_pkg::OUTQ_DEPTH + 1);

  s2dma_pkg::res_t mem [s2dma_pkg::OUTQ_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            pop;

  assign dvalid = count != '0;
  assign dout   = mem[rd_ptr];
  assign pop    = dvalid && dready;
  assign room2  = count <= CW'(s2dma_pkg::OUTQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (npush != 2'd0) begin
      mem[wr_ptr] <= din0;
    end
    if (npush == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(npush);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count + CW'(npush) - CW'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== tb/dma_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker of the strided 2-D DMA engine: watches the configuration, request and
// result ports, predicts every result from its own engine state and compares in order.
// Depends on s2dma_pkg.
module dma_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          owed_count
);

  localparam int RF_BYTES = s2dma_pkg::REG_WORDS_DEF * 4;

  logic [7:0]      rf_mem [RF_BYTES];
  logic            xfer_busy;
  logic [31:0]     row_idx;
  logic [31:0]     row_off;
  logic [31:0]     src_base;
  logic [31:0]     dst_base;
  logic [31:0]     wr_dest;
  logic [31:0]     wr_count;
  logic [31:0]     geo_h;
  logic [31:0]     geo_w;
  logic [31:0]     geo_ss;
  logic [31:0]     geo_ds;
  logic [31:0]     win_base;
  logic [4:0]      win_span;
  s2dma_pkg::res_t owed_results [$];

  function automatic logic [31:0] rf_word(int w);
    return {rf_mem[4 * w + 3], rf_mem[4 * w + 2], rf_mem[4 * w + 1], rf_mem[4 * w]};
  endfunction

  task automatic owe(s2dma_pkg::kind_t k, logic [31:0] a, logic [31:0] d, logic [2:0] vb,
                     s2dma_pkg::err_t e, logic l);
    s2dma_pkg::res_t r;
    r.out_kind    = k;
    r.out_addr    = a;
    r.out_data    = d;
    r.valid_bytes = vb;
    r.error_code  = e;
    r.last        = l;
    owed_results.push_back(r);
  endtask

  task automatic owe_chunk_read();
    logic [31:0] left;
    left     = geo_w - row_off;
    wr_count = (left >= 32'd4) ? 32'd4 : left;
    wr_dest  = dst_base + row_off;
    owe(s2dma_pkg::KIND_MRD, src_base + row_off, '0, 3'd4, s2dma_pkg::ERR_NONE, 1'b1);
  endtask

  task automatic apply_request(s2dma_pkg::req_t q);
    int unsigned nb;
    int unsigned lim;
    int unsigned i;
    logic [31:0] off;
    logic [31:0] v;
    logic [31:0] sgn;
    logic [31:0] w3;
    logic [31:0] h;
    logic [31:0] w;
    logic [31:0] ds;
    logic [31:0] ss;
    logic [31:0] a;
    logic [31:0] cnt;
    logic        hit;
    logic        fin;
    nb  = (q.access_size == s2dma_pkg::SIZE_BYTE) ? 1 :
          (q.access_size == s2dma_pkg::SIZE_HALF) ? 2 : 4;
    lim = (win_span < RF_BYTES) ? win_span : RF_BYTES;
    off = q.bus_addr - win_base;
    hit = (64'(off) + 64'(nb)) <= 64'(lim);
    case (q.req_type)
      s2dma_pkg::REQ_READ: begin
        if (!hit) begin
          owe(s2dma_pkg::KIND_RDATA, '0, '0, 3'd0, s2dma_pkg::ERR_RANGE, 1'b1);
        end else begin
          v = '0;
          for (i = 0; i < nb; i++) v |= 32'(rf_mem[off + i]) << (8 * i);
          if (q.sign_extend && nb < 4) begin
            sgn = 32'd1 << (8 * nb - 1);
            if ((v & sgn) != 0) v |= ~((sgn << 1) - 32'd1);
          end
          owe(s2dma_pkg::KIND_RDATA, '0, v, 3'd0, s2dma_pkg::ERR_NONE, 1'b1);
        end
      end
      s2dma_pkg::REQ_WRITE: begin
        if (!hit) begin
          owe(s2dma_pkg::KIND_WDONE, '0, '0, 3'd0, s2dma_pkg::ERR_RANGE, 1'b1);
        end else begin
          for (i = 0; i < nb; i++) rf_mem[off + i] = q.payload[8 * i +: 8];
          if (xfer_busy || !rf_mem[0][0]) begin
            owe(s2dma_pkg::KIND_WDONE, '0, '0, 3'd0, s2dma_pkg::ERR_NONE, 1'b1);
          end else begin
            w3 = rf_word(s2dma_pkg::WORD_GEOM);
            h  = 32'(w3[7:0]) + 32'd1;
            w  = 32'(w3[15:8]) + 32'd1;
            ds = 32'(w3[23:16]);
            ss = 32'(w3[31:24]);
            if (h > 1 && (ss < w || ds < w)) begin
              owe(s2dma_pkg::KIND_WDONE, '0, '0, 3'd0, s2dma_pkg::ERR_CONFIG, 1'b1);
            end else begin
              geo_h     = h;
              geo_w     = w;
              geo_ds    = ds;
              geo_ss    = ss;
              xfer_busy = 1'b1;
              row_idx   = '0;
              row_off   = '0;
              src_base  = rf_word(s2dma_pkg::WORD_SRC);
              dst_base  = rf_word(s2dma_pkg::WORD_DST);
              owe(s2dma_pkg::KIND_WDONE, '0, '0, 3'd0, s2dma_pkg::ERR_NONE, 1'b0);
              owe_chunk_read();
            end
          end
        end
      end
      s2dma_pkg::REQ_RETURN: begin
        if (xfer_busy) begin
          a       = wr_dest;
          cnt     = wr_count;
          fin     = 1'b0;
          row_off = row_off + cnt;
          if (row_off >= geo_w) begin
            row_off = '0;
            if (row_idx + 32'd1 >= geo_h) begin
              fin = 1'b1;
            end else begin
              row_idx  = row_idx + 32'd1;
              src_base = src_base + geo_ss;
              dst_base = dst_base + geo_ds;
            end
          end
          owe(s2dma_pkg::KIND_MWR, a, q.payload, cnt[2:0], s2dma_pkg::ERR_NONE, fin);
          if (fin) begin
            xfer_busy                             = 1'b0;
            rf_mem[s2dma_pkg::WORD_CTRL * 4][0]   = 1'b0;
            rf_mem[s2dma_pkg::WORD_STATUS * 4][0] = 1'b1;
          end else begin
            owe_chunk_read();
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    s2dma_pkg::res_t want;
    s2dma_pkg::req_t q;
    if (rst) begin
      foreach (rf_mem[i]) rf_mem[i] = '0;
      xfer_busy  = 1'b0;
      row_idx    = '0;
      row_off    = '0;
      src_base   = '0;
      dst_base   = '0;
      wr_dest    = '0;
      wr_count   = '0;
      geo_h      = '0;
      geo_w      = '0;
      geo_ss     = '0;
      geo_ds     = '0;
      win_base   = '0;
      win_span   = 5'd24;
      fail_count = 0;
      owed_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == s2dma_pkg::CFG_REGION_BASE) win_base = cfg_wdata;
        else win_span = cfg_wdata[4:0];
      end
      if (m_tvalid && m_tready) begin
        if (owed_results.size() == 0) begin
          $error("result with nothing expected: kind %0d addr 0x%0h data 0x%0h",
                 m_tuser, m_tdata[31:0], m_tdata[63:32]);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("out_kind", want.out_kind, m_tuser);
          check_field("out_addr", want.out_addr, m_tdata[31:0]);
          check_field("out_data", want.out_data, m_tdata[63:32]);
          check_field("valid_bytes", want.valid_bytes, m_tdata[66:64]);
          check_field("error_code", want.error_code, m_tdata[68:67]);
          check_field("last", want.last, m_tlast);
        end
      end
      if (s_tvalid && s_tready) begin
        q.req_type    = s2dma_pkg::req_type_t'(s_tuser);
        q.bus_addr    = s_tdata[31:0];
        q.access_size = s_tdata[33:32];
        q.sign_extend = s_tdata[34];
        q.payload     = s_tdata[66:35];
        apply_request(q);
      end
    end
    owed_count = owed_results.size();
  end

endmodule

// ===== tb/tb_strided_2d_dma_engine.sv =====
`timescale 1ns / 1ps
// Testbench top of the strided 2-D DMA engine: clock, reset, region settings, request
// stimulus and result back-pressure, and the verdict.
// Depends on s2dma_pkg, strided_2d_dma_engine and dma_result_checker.
module tb_strided_2d_dma_engine;

  localparam int         RUN_LIMIT    = 1000000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 16;
  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam logic [1:0] SIZE_THREE   = 2'd3;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_idx   = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic [71:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tready  = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  int          fail_count;
  int          owed_count;
  int          sent     = 0;
  int          cycles   = 0;
  logic [31:0] cur_base = '0;
  bit          tx_calm  = 1'b0;
  logic        rx_calm  = 1'b0;
  logic        hold_ask = 1'b0;

  strided_2d_dma_engine u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  dma_result_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .fail_count(fail_count),
    .owed_count(owed_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_calm || $urandom_range(0, 99) < 60) begin
        m_tready <= 1'b1;
      end else begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        m_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end
    end
  end

  task automatic send_req(logic [1:0] kind, logic [31:0] addr, logic [1:0] sz, logic sx,
                          logic [31:0] pl);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (tx_calm || pick < 65) gap = 0;
    else if (pick < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'd0, pl, sx, sz, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic reg_wr(int word, logic [31:0] val);
    send_req(s2dma_pkg::REQ_WRITE, cur_base + 32'(4 * word), s2dma_pkg::SIZE_WORD, 1'b0,
             val);
  endtask

  task automatic send_noise();
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] pl;
    int          pick;
    pick = $urandom_range(0, 99);
    kind = (pick < 40) ? s2dma_pkg::REQ_READ : (pick < 75) ? s2dma_pkg::REQ_WRITE :
           (pick < 93) ? s2dma_pkg::REQ_RETURN : REQ_UNUSED;
    addr = ($urandom_range(0, 4) == 0) ? $urandom : cur_base + $urandom_range(0, 27);
    pl   = $urandom;
    // keep most stray writes from starting transfers of random geometry
    if (addr == cur_base && $urandom_range(0, 9) != 0) pl[0] = 1'b0;
    send_req(kind, addr, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pl);
  endtask

  task automatic run_xfer(logic [31:0] src, logic [31:0] dst, logic [31:0] geom, int nret);
    reg_wr(s2dma_pkg::WORD_SRC, src);
    reg_wr(s2dma_pkg::WORD_DST, dst);
    reg_wr(s2dma_pkg::WORD_GEOM, geom);
    reg_wr(s2dma_pkg::WORD_CTRL, $urandom | 32'd1);
    for (int k = 0; k < nret; k++) begin
      if ($urandom_range(0, 9) < 2) send_noise();
      send_req(s2dma_pkg::REQ_RETURN, $urandom, 2'($urandom_range(0, 3)),
               1'($urandom_range(0, 1)), $urandom);
    end
  endtask

  task automatic set_region(logic [31:0] base, logic [31:0] span);
    cfg_we    <= 1'b1;
    cfg_idx   <= s2dma_pkg::CFG_REGION_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_idx   <= s2dma_pkg::CFG_REGION_BYTES;
    cfg_wdata <= span;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_base   = base;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (owed_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] nb_base;
    logic [31:0] nb_span;
    int          quota;
    int          goal;
    int          pick;
    int          h1;
    int          w1;
    int          wd;
    int          ss;
    int          ds;
    int          nret;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_region(32'h0, 32'd24);

    send_req(s2dma_pkg::REQ_READ, 32'd0, s2dma_pkg::SIZE_WORD, 1'b0, 32'h0);
    reg_wr(s2dma_pkg::WORD_SRC, 32'hFFFF_FFFC);
    reg_wr(s2dma_pkg::WORD_DST, 32'hFFFF_FFFE);
    send_req(s2dma_pkg::REQ_WRITE, 32'd16, SIZE_THREE, 1'b0, 32'h8000_FF80);
    send_req(s2dma_pkg::REQ_READ, 32'd16, s2dma_pkg::SIZE_BYTE, 1'b1, 32'hFFFF_FFFF);
    send_req(s2dma_pkg::REQ_READ, 32'd16, s2dma_pkg::SIZE_BYTE, 1'b0, 32'h0);
    send_req(s2dma_pkg::REQ_READ, 32'd18, s2dma_pkg::SIZE_HALF, 1'b1, 32'h0);
    send_req(s2dma_pkg::REQ_READ, 32'd17, s2dma_pkg::SIZE_HALF, 1'b1, 32'h0);
    send_req(s2dma_pkg::REQ_READ, 32'd16, SIZE_THREE, 1'b1, 32'h0);
    send_req(s2dma_pkg::REQ_READ, 32'd21, s2dma_pkg::SIZE_WORD, 1'b0, 32'h0);
    send_req(s2dma_pkg::REQ_READ, 32'd22, s2dma_pkg::SIZE_HALF, 1'b0, 32'h0);
    send_req(s2dma_pkg::REQ_READ, 32'hFFFF_FFFF, s2dma_pkg::SIZE_BYTE, 1'b0, 32'h0);
    send_req(s2dma_pkg::REQ_WRITE, 32'd24, s2dma_pkg::SIZE_WORD, 1'b0, 32'hFFFF_FFFF);
    send_req(s2dma_pkg::REQ_WRITE, 32'd23, s2dma_pkg::SIZE_BYTE, 1'b1, 32'h0000_00A5);
    send_req(s2dma_pkg::REQ_RETURN, 32'hFFFF_FFFF, s2dma_pkg::SIZE_WORD, 1'b1,
             32'h1234_5678);
    send_req(REQ_UNUSED, 32'd0, s2dma_pkg::SIZE_WORD, 1'b0, 32'hFFFF_FFFF);
    reg_wr(s2dma_pkg::WORD_GEOM, {8'd8, 8'd4, 8'd7, 8'd1});
    reg_wr(s2dma_pkg::WORD_CTRL, 32'd1);
    send_req(s2dma_pkg::REQ_READ, 32'd0, s2dma_pkg::SIZE_WORD, 1'b0, 32'h0);
    // start bit is still set, so a good geometry starts the copy
    reg_wr(s2dma_pkg::WORD_GEOM, {8'd7, 8'd5, 8'd4, 8'd1});
    send_req(s2dma_pkg::REQ_RETURN, 32'h0, s2dma_pkg::SIZE_WORD, 1'b0, 32'hFFFF_FFFF);
    reg_wr(s2dma_pkg::WORD_CTRL, 32'hFFFF_FFFF);
    send_req(s2dma_pkg::REQ_RETURN, 32'h0, s2dma_pkg::SIZE_WORD, 1'b0, 32'h0);
    send_req(s2dma_pkg::REQ_RETURN, 32'h0, s2dma_pkg::SIZE_WORD, 1'b0, 32'hA5A5_5A5A);
    send_req(s2dma_pkg::REQ_RETURN, 32'h0, s2dma_pkg::SIZE_WORD, 1'b0, 32'h0F0F_F0F0);
    send_req(s2dma_pkg::REQ_READ, 32'd20, s2dma_pkg::SIZE_BYTE, 1'b1, 32'h0);
    run_xfer(32'h0, 32'hFFFF_FFFF, 32'h0, 1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       begin nb_base = 32'h0000_1000; nb_span = 32'd24;        quota = 330; end
        1:       begin nb_base = 32'hFFFF_FFF0; nb_span = 32'd31;        quota = 330; end
        2:       begin nb_base = 32'h8000_0000; nb_span = 32'd12;        quota = 150; end
        3:       begin nb_base = 32'h7FFF_FFFF; nb_span = 32'd0;         quota = 40;  end
        4:       begin nb_base = 32'h0;         nb_span = 32'hFFFF_FFF8; quota = 330; end
        default: begin nb_base = $urandom;      nb_span = 32'd20;        quota = 300; end
      endcase
      wait_idle();
      set_region(nb_base, nb_span);
      tx_calm  = (ph == 4);
      rx_calm <= (ph == 4);
      goal     = sent + quota;
      if (ph == 0) begin
        // hold the result side off while requests keep coming
        tx_calm   = 1'b1;
        hold_ask <= 1'b1;
        repeat (40) send_noise();
        tx_calm   = 1'b0;
      end
      while (sent < goal) begin
        if ($urandom_range(0, 9) < 7) begin
          pick = $urandom_range(0, 99);
          if (pick < 2) begin
            h1 = 0;
            w1 = 255;
          end else if (pick < 3) begin
            h1 = 255;
            w1 = $urandom_range(0, 3);
          end else begin
            h1 = $urandom_range(0, 3);
            w1 = $urandom_range(0, 11);
          end
          wd = w1 + 1;
          if ($urandom_range(0, 9) == 0) begin
            ss = $urandom_range(0, 255);
            ds = $urandom_range(0, 255);
          end else begin
            ss = wd + $urandom_range(0, 8);
            ds = wd + $urandom_range(0, 8);
            if (ss > 255) ss = 255;
            if (ds > 255) ds = 255;
          end
          nret = (h1 > 0 && (ss < wd || ds < wd)) ? 2 : ((wd + 3) / 4) * (h1 + 1);
          run_xfer($urandom, $urandom, {ss[7:0], ds[7:0], w1[7:0], h1[7:0]}, nret);
        end else begin
          repeat ($urandom_range(1, 5)) send_noise();
        end
      end
    end

    wait_idle();
    @(negedge clk);
    if (fail_count == 0 && owed_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== strided_2d_dma_engine.f =====
rtl/s2dma_pkg.sv
rtl/s2dma_exec.sv
rtl/s2dma_outq.sv
rtl/strided_2d_dma_engine.sv
tb/dma_result_checker.sv
tb/tb_strided_2d_dma_engine.sv
